FILE: rtl/core/audio_fade_track_switcher_unit_defines.svh
// assertion macros shared by the fade and track-switch rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef AUDIO_FADE_TRACK_SWITCHER_UNIT_DEFINES_SVH
`define AUDIO_FADE_TRACK_SWITCHER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define AFTS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define AFTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/afts_pkg.sv
// constants and codes for the fade and track-switch controller
// no dependencies; imported by afts_if and audio_fade_track_switcher_unit
package afts_pkg;

  localparam int unsigned Q_W       = 17;   // unsigned q1.16 width
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned MODE_W    = 2;

  localparam logic [Q_W-1:0] UNITY       = 17'h10000;
  localparam logic [Q_W-1:0] VOLUME_RST  = 17'h10000;
  localparam logic [Q_W-1:0] STEP_RST    = 17'd1092;

  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_STOPPED  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FADE_IN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PLAYING  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FADE_OUT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE      = 2'd2;

endpackage

FILE: rtl/core/afts_if.sv
// valid/ready channel interfaces for input items and result items
// depends on afts_pkg
interface afts_in_if
  import afts_pkg::*;
#(
  parameter int unsigned TRACK_BITS  = 4,
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               opcode;
  logic [TRACK_BITS-1:0]         track_id;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, opcode, track_id, left_in, right_in, input ready);
  modport sink (input valid, opcode, track_id, left_in, right_in, output ready);
endinterface

interface afts_out_if
  import afts_pkg::*;
#(
  parameter int unsigned TRACK_BITS  = 4,
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          sample_valid;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          load_request;
  logic [TRACK_BITS-1:0]         load_track;
  logic                          flush;
  logic [MODE_W-1:0]             play_state;
  logic [Q_W-1:0]                fade_level;
  logic [TRACK_BITS-1:0]         current_track;

  modport source (output valid, sample_valid, left_out, right_out, load_request,
                  load_track, flush, play_state, fade_level, current_track,
                  input ready);
  modport sink (input valid, sample_valid, left_out, right_out, load_request,
                load_track, flush, play_state, fade_level, current_track,
                output ready);
endinterface

FILE: rtl/core/audio_fade_track_switcher_unit.sv
// top level of the fade and track-switch controller for stereo audio
// depends on afts_pkg, afts_if (afts_in_if, afts_out_if), afts_serial_mul
//
//  channel   direction  transaction
//  in_i      sink       tick, track request or stereo sample pair
//  out_o     source     one status/sample result per input transaction
//  cfg_*     write      volume, fade_step, mute
//
// ticks, track requests, ignored opcodes and samples while stopped or muted
// load the result register at the accept edge
// a sample pair while playing and unmuted runs from accept to result through the gain
// multiplier, the left and right scalers, their done pulses and the hold state
// a result waits in the output register; a stalled output blocks new input
// reset is asynchronous active low and leaves the block stopped, fade zero
`include "audio_fade_track_switcher_unit_defines.svh"

module audio_fade_track_switcher_unit
  import afts_pkg::*;
#(
  parameter int unsigned TRACK_BITS  = 4,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  afts_in_if.sink               in_i,
  afts_out_if.source            out_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_GAIN  = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  localparam int unsigned PW = Q_W + SAMPLE_BITS;

  // configuration
  logic [Q_W-1:0] volume_q, fade_step_q;
  logic           mute_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q    <= VOLUME_RST;
      fade_step_q <= STEP_RST;
      mute_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VOLUME:    volume_q    <= cfg_data_i[Q_W-1:0];
        CFG_FADE_STEP: fade_step_q <= cfg_data_i[Q_W-1:0];
        CFG_MUTE:      mute_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // player state
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [Q_W-1:0]        fade_q, fade_d;
  logic                  playing_q, playing_d;
  logic [TRACK_BITS-1:0] now_q, now_d, wanted_q, wanted_d;
  logic                  load_req;
  logic [TRACK_BITS-1:0] load_trk;
  logic                  flush;

  logic [1:0] state_q, state_d;
  logic       out_valid_q;
  logic       out_free, in_acc, sample_go, load_ctl, load_smp;

  logic [Q_W-1:0] step, vol_clamp, fade_dec;
  logic [Q_W:0]   fade_sum;

  assign step      = (fade_step_q > UNITY) ? UNITY : fade_step_q;
  assign vol_clamp = (volume_q > UNITY) ? UNITY : volume_q;
  assign fade_sum  = {1'b0, fade_q} + {1'b0, step};
  assign fade_dec  = (fade_q > step) ? (fade_q - step) : '0;

  always_comb begin
    mode_d    = mode_q;
    fade_d    = fade_q;
    playing_d = playing_q;
    now_d     = now_q;
    wanted_d  = wanted_q;
    load_req  = 1'b0;
    load_trk  = '0;
    flush     = 1'b0;
    case (in_i.opcode)
      OP_TICK: begin
        if (mode_q == MODE_FADE_IN) begin
          if (fade_sum >= {1'b0, UNITY}) begin
            fade_d = UNITY;
            mode_d = MODE_PLAYING;
          end else begin
            fade_d = fade_sum[Q_W-1:0];
          end
        end else if (mode_q == MODE_FADE_OUT) begin
          fade_d = fade_dec;
          if (fade_dec == '0) begin
            playing_d = 1'b0;
            mode_d    = MODE_STOPPED;
            flush     = 1'b1;
            now_d     = '0;
            // queued track starts right away from silence
            if (wanted_q != '0) begin
              load_req  = 1'b1;
              load_trk  = wanted_q;
              now_d     = wanted_q;
              playing_d = 1'b1;
              fade_d    = '0;
              mode_d    = MODE_FADE_IN;
            end
          end
        end
      end
      OP_REQUEST: begin
        if (in_i.track_id != wanted_q) begin
          wanted_d = in_i.track_id;
          if (in_i.track_id == now_q) begin
            if (mode_q == MODE_FADE_OUT) begin
              mode_d = MODE_FADE_IN;
            end
          end else if (now_q == '0) begin
            load_req = 1'b1;
            load_trk = in_i.track_id;
            now_d    = in_i.track_id;
            if (playing_q) begin
              if (mode_q == MODE_FADE_OUT) begin
                mode_d = MODE_FADE_IN;
              end
            end else begin
              playing_d = 1'b1;
              fade_d    = '0;
              mode_d    = MODE_FADE_IN;
            end
          end else begin
            mode_d = MODE_FADE_OUT;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_acc    = in_i.valid && in_i.ready;
  assign sample_go = (in_i.opcode == OP_SAMPLE) && playing_q && !mute_q;
  assign load_ctl  = in_acc && !sample_go;
  assign load_smp  = (state_q == ST_HOLD) && out_free;

  assign in_i.ready = (state_q == ST_IDLE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_STOPPED;
      fade_q    <= '0;
      playing_q <= 1'b0;
      now_q     <= '0;
      wanted_q  <= '0;
    end else if (in_acc) begin
      mode_q    <= mode_d;
      fade_q    <= fade_d;
      playing_q <= playing_d;
      now_q     <= now_d;
      wanted_q  <= wanted_d;
    end
  end

  // sample magnitudes, scaled bit-serially and re-signed at the end
  logic [SAMPLE_BITS-1:0] l_mag_q, r_mag_q;
  logic                   l_neg_q, r_neg_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && sample_go) begin
      l_neg_q <= in_i.left_in[SAMPLE_BITS-1];
      r_neg_q <= in_i.right_in[SAMPLE_BITS-1];
      l_mag_q <= in_i.left_in[SAMPLE_BITS-1] ? (-in_i.left_in) : in_i.left_in;
      r_mag_q <= in_i.right_in[SAMPLE_BITS-1] ? (-in_i.right_in) : in_i.right_in;
    end
  end

  logic            gain_done, l_done, r_done;
  logic [2*Q_W-1:0] gain_prod;
  logic [Q_W-1:0]  gain;
  logic [PW-1:0]   l_prod, r_prod;

  assign gain = gain_prod[FRAC_BITS +: Q_W];

  afts_serial_mul #(.AW(Q_W), .BW(Q_W)) u_gain_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && sample_go),
    .a_i     (vol_clamp),
    .b_i     (fade_q),
    .done_o  (gain_done),
    .prod_o  (gain_prod)
  );

  afts_serial_mul #(.AW(Q_W), .BW(SAMPLE_BITS)) u_left_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gain_done),
    .a_i     (gain),
    .b_i     (l_mag_q),
    .done_o  (l_done),
    .prod_o  (l_prod)
  );

  afts_serial_mul #(.AW(Q_W), .BW(SAMPLE_BITS)) u_right_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gain_done),
    .a_i     (gain),
    .b_i     (r_mag_q),
    .done_o  (r_done),
    .prod_o  (r_prod)
  );

  logic [SAMPLE_BITS-1:0] l_res_mag, r_res_mag, l_res, r_res;

  // gain never exceeds unity, so the magnitude fits the sample width
  assign l_res_mag = l_prod[FRAC_BITS +: SAMPLE_BITS];
  assign r_res_mag = r_prod[FRAC_BITS +: SAMPLE_BITS];
  assign l_res     = l_neg_q ? (-l_res_mag) : l_res_mag;
  assign r_res     = r_neg_q ? (-r_res_mag) : r_res_mag;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc && sample_go) state_d = ST_GAIN;
      ST_GAIN:  if (gain_done) state_d = ST_SCALE;
      ST_SCALE: if (l_done && r_done) state_d = ST_HOLD;
      ST_HOLD:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_ctl || load_smp) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  logic                   o_svalid_q, o_load_q, o_flush_q;
  logic [SAMPLE_BITS-1:0] o_left_q, o_right_q;
  logic [TRACK_BITS-1:0]  o_ltrk_q, o_track_q;
  logic [MODE_W-1:0]      o_mode_q;
  logic [Q_W-1:0]         o_fade_q;

  always_ff @(posedge clk_i) begin
    if (load_ctl) begin
      o_svalid_q <= 1'b0;
      o_left_q   <= '0;
      o_right_q  <= '0;
      o_load_q   <= load_req;
      o_ltrk_q   <= load_trk;
      o_flush_q  <= flush;
      o_mode_q   <= mode_d;
      o_fade_q   <= fade_d;
      o_track_q  <= now_d;
    end else if (load_smp) begin
      o_svalid_q <= 1'b1;
      o_left_q   <= l_res;
      o_right_q  <= r_res;
      o_load_q   <= 1'b0;
      o_ltrk_q   <= '0;
      o_flush_q  <= 1'b0;
      o_mode_q   <= mode_q;
      o_fade_q   <= fade_q;
      o_track_q  <= now_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.sample_valid  = o_svalid_q;
  assign out_o.left_out      = o_left_q;
  assign out_o.right_out     = o_right_q;
  assign out_o.load_request  = o_load_q;
  assign out_o.load_track    = o_ltrk_q;
  assign out_o.flush         = o_flush_q;
  assign out_o.play_state    = o_mode_q;
  assign out_o.fade_level    = o_fade_q;
  assign out_o.current_track = o_track_q;

  `AFTS_ASSERT_NOW(a_fade_range, clk_i, rst_ni, 1'b1, fade_q <= UNITY,
                   "fade level above unity")
  `AFTS_ASSERT_NOW(a_stopped_idle, clk_i, rst_ni, 1'b1,
                   (mode_q == MODE_STOPPED) == !playing_q,
                   "stopped mode and playing flag disagree")
  `AFTS_ASSERT_NOW(a_unused_zero, clk_i, rst_ni, out_valid_q && !o_svalid_q,
                   o_left_q == '0 && o_right_q == '0,
                   "sample fields not cleared on a non-sample result")
  `AFTS_ASSERT_NOW(a_ready_idle, clk_i, rst_ni, in_i.ready, state_q == ST_IDLE,
                   "input taken while a sample is in flight")

endmodule

FILE: rtl/core/afts_serial_mul.sv
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
// depends on the assertion macro header
`include "audio_fade_track_switcher_unit_defines.svh"

module afts_serial_mul #(
  parameter int unsigned AW = 17,
  parameter int unsigned BW = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW-1:0]    a_q;
  logic [AW+BW-1:0] prod_q, prod_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [AW:0]      sum;

  // upper half accumulates, lower half shifts the multiplier bits out
  assign sum = {1'b0, prod_q[AW+BW-1:BW]} + (prod_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    prod_d = prod_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      prod_d = {{AW{1'b0}}, b_i};
      cnt_d  = CW'(BW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      prod_d = {sum, prod_q[BW-1:1]};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

  `AFTS_ASSERT_NOW(a_mul_start_idle, clk_i, rst_ni, start_i, !busy_q,
                   "multiplier started while busy")
  `AFTS_ASSERT_NEXT(a_mul_last_step, clk_i, rst_ni, busy_q && !start_i && cnt_q == CW'(1),
                    done_q && !busy_q, "multiplier missed its done pulse")
  `AFTS_ASSERT_NEXT(a_mul_done_pulse, clk_i, rst_ni, done_q && !start_i, !done_q,
                    "multiplier done held longer than one cycle")

endmodule
